@@ rtl/core/cer_pkg.sv @@
package cer_pkg;

    // Hit store geometry and counter limit.
    localparam int unsigned COUNTER_DEPTH = 65536;
    localparam int unsigned CNT_AW        = $clog2(COUNTER_DEPTH);
    localparam int unsigned GUARD_IDX_W   = 28;
    localparam logic [7:0]  HIT_LIMIT     = 8'd255;
    localparam logic [31:0] IDX_MASK      = 32'h0fff_ffff;

    typedef logic [CNT_AW-1:0]      t_cidx;
    typedef logic [GUARD_IDX_W-1:0] t_gidx;
    typedef logic [GUARD_IDX_W:0]   t_gcmp;

    localparam t_gcmp DEPTH_CMP = t_gcmp'(COUNTER_DEPTH);

    // Register map, indexed by paddr[3:2].
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_ENABLE = 2'd1;
    localparam logic [1:0] REG_MAX    = 2'd2;

    localparam logic [31:0] MAX_ENTRIES_RST = 32'h0001_0000;

    // Recording modes.
    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_PC       = 2'd1;
    localparam logic [1:0] MODE_PC_STACK = 2'd2;
    localparam logic [1:0] MODE_COUNT    = 2'd3;

    // Input operations.
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_WRITTEN = 3'd1,
        ST_FULL    = 3'd2,
        ST_COUNTED = 3'd3,
        ST_SATURATED = 3'd4,
        ST_RANGE   = 3'd5,
        ST_READ    = 3'd6
    } t_status;

    typedef struct packed {
        logic        op;
        logic        thread_attached;
        logic [63:0] return_addr;
        logic [31:0] guard_word;
        logic [31:0] stack_size;
        logic [15:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] entry_index;
        logic [63:0] entry_pc;
        logic [31:0] entry_stack;
        logic [7:0]  hit_count;
        logic [31:0] trace_count;
    } t_out_item;

endpackage

@@ rtl/core/coverage_event_recorder.sv @@
// Coverage event recorder.
// Input transactions (i_in_valid/o_in_ready, payload i_in_data) carry either a
// coverage event or a request to read one hit counter. Every input transaction
// yields exactly one output transaction (o_out_valid/i_out_ready, o_out_data).
// Trace modes hand out successive trace slots until max_entries is reached;
// counter mode increments an 8-bit hit counter held in a 64K-entry memory.
// A result passes the second-stage register and then the output register.
// Throughput is one transaction per cycle while the receiver is ready: a
// read-modify-write of the hit memory is split across the accept cycle (read
// issued) and the cycle in which the second stage retires (update written),
// with the last write forwarded to a following read of the same entry.
// After reset the hit memory is cleared by a sweep over all 65536 entries,
// during which o_in_ready stays low; configuration writes are taken throughout.
// When the receiver stalls, the result is held in the output register and the
// pipeline stops behind it, so o_in_ready falls once both stages are full.
// Configuration is written through the APB-style port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module coverage_event_recorder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cer_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cer_pkg::t_out_item o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Configuration registers.
    logic [1:0]  r_record_mode;
    logic        r_recording_enabled;
    logic [31:0] r_max_entries;

    // Trace head.
    logic [31:0] r_head;
    logic [31:0] n_head;

    // Second stage.
    logic              r_s1_valid;
    cer_pkg::t_in_item r_s1_item;
    cer_pkg::t_gidx    r_s1_idx;
    logic              r_s1_in_range;

    // Last write to the hit memory, for forwarding.
    logic           r_fwd_valid;
    cer_pkg::t_cidx r_fwd_addr;
    logic [7:0]     r_fwd_data;

    // Output register.
    logic               r_out_valid;
    cer_pkg::t_out_item r_out_data;
    cer_pkg::t_out_item n_out_data;

    logic           clearing;
    logic [7:0]     ram_rd_data;
    logic           in_accept;
    logic           s1_adv;
    cer_pkg::t_gidx s0_idx;
    logic           s0_in_range;
    logic [7:0]     cur_count;
    logic [7:0]     inc_count;
    logic           cnt_wr;
    logic           cfg_wr;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (paddr[3:2])
            cer_pkg::REG_MODE:   prdata = {30'd0, r_record_mode};
            cer_pkg::REG_ENABLE: prdata = {31'd0, r_recording_enabled};
            cer_pkg::REG_MAX:    prdata = r_max_entries;
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_mode       <= cer_pkg::MODE_NONE;
            r_recording_enabled <= 1'b0;
            r_max_entries       <= cer_pkg::MAX_ENTRIES_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                cer_pkg::REG_MODE:   r_record_mode       <= pwdata[1:0];
                cer_pkg::REG_ENABLE: r_recording_enabled <= pwdata[0];
                cer_pkg::REG_MAX:    r_max_entries       <= pwdata;
                default: ;
            endcase
        end
    end

    // Handshake: the second stage moves on whenever the output register frees up.
    assign s1_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready  = !clearing && (!r_s1_valid || s1_adv);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // First stage: choose the counter index and issue the memory read.
    always_comb begin
        if (i_in_data.op == cer_pkg::OP_READ) begin
            s0_idx = cer_pkg::t_gidx'(i_in_data.read_index);
        end else begin
            s0_idx = cer_pkg::t_gidx'(i_in_data.guard_word & cer_pkg::IDX_MASK);
        end
        s0_in_range = cer_pkg::t_gcmp'(s0_idx) < cer_pkg::DEPTH_CMP;
    end

    cer_hit_store u_hit_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_accept),
        .i_rd_addr  (cer_pkg::t_cidx'(s0_idx)),
        .o_rd_data  (ram_rd_data),
        .i_wr_en    (cnt_wr),
        .i_wr_addr  (cer_pkg::t_cidx'(r_s1_idx)),
        .i_wr_data  (inc_count),
        .o_clearing (clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || s1_adv) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item     <= i_in_data;
            r_s1_idx      <= s0_idx;
            r_s1_in_range <= s0_in_range;
        end
    end

    // Second stage: take the freshest counter value, forwarding the last write.
    always_comb begin
        if (r_fwd_valid && r_fwd_addr == cer_pkg::t_cidx'(r_s1_idx)) begin
            cur_count = r_fwd_data;
        end else begin
            cur_count = ram_rd_data;
        end
        inc_count = cur_count + 8'd1;
    end

    // Second stage: work out the result and the state update.
    always_comb begin
        n_head     = r_head;
        cnt_wr     = 1'b0;
        n_out_data = '0;
        if (r_s1_item.op == cer_pkg::OP_READ) begin
            n_out_data.entry_index = 32'(r_s1_idx);
            if (r_s1_in_range) begin
                n_out_data.status    = cer_pkg::ST_READ;
                n_out_data.hit_count = cur_count;
            end else begin
                n_out_data.status = cer_pkg::ST_RANGE;
            end
        end else if (!r_s1_item.thread_attached || !r_recording_enabled
                     || r_record_mode == cer_pkg::MODE_NONE) begin
            n_out_data.status = cer_pkg::ST_IGNORED;
        end else if (r_record_mode == cer_pkg::MODE_COUNT) begin
            n_out_data.entry_index = 32'(r_s1_idx);
            if (!r_s1_in_range) begin
                n_out_data.status = cer_pkg::ST_RANGE;
            end else if (cur_count < cer_pkg::HIT_LIMIT) begin
                n_out_data.status    = cer_pkg::ST_COUNTED;
                n_out_data.hit_count = inc_count;
                cnt_wr               = r_s1_valid && s1_adv;
            end else begin
                n_out_data.status    = cer_pkg::ST_SATURATED;
                n_out_data.hit_count = cur_count;
            end
        end else if (r_head >= r_max_entries) begin
            n_out_data.status = cer_pkg::ST_FULL;
        end else begin
            n_out_data.status      = cer_pkg::ST_WRITTEN;
            n_out_data.entry_index = r_head;
            n_out_data.entry_pc    = r_s1_item.return_addr - 64'd1;
            if (r_record_mode == cer_pkg::MODE_PC_STACK) begin
                n_out_data.entry_stack = r_s1_item.stack_size;
            end
            n_head = r_head + 32'd1;
        end
        n_out_data.trace_count = n_head;
    end

    // State update and result capture as the second stage retires.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= 32'd0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (r_s1_valid && s1_adv) begin
                r_head <= n_head;
            end
            if (cnt_wr) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_data <= n_out_data;
        end
        if (cnt_wr) begin
            r_fwd_addr <= cer_pkg::t_cidx'(r_s1_idx);
            r_fwd_data <= inc_count;
        end
    end

endmodule

@@ rtl/core/cer_hit_store.sv @@
module cer_hit_store (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  cer_pkg::t_cidx i_rd_addr,
    output logic [7:0]    o_rd_data,
    input  logic          i_wr_en,
    input  cer_pkg::t_cidx i_wr_addr,
    input  logic [7:0]    i_wr_data,
    output logic          o_clearing
);

    logic [7:0]     r_mem [cer_pkg::COUNTER_DEPTH];
    logic [7:0]     r_rd_data;
    logic           r_clearing;
    cer_pkg::t_cidx r_clr_addr;

    logic           wr_en;
    cer_pkg::t_cidx wr_addr;
    logic [7:0]     wr_data;

    // The clearing sweep owns the write port until every entry is zero.
    always_comb begin
        wr_en   = r_clearing | i_wr_en;
        wr_addr = r_clearing ? r_clr_addr : i_wr_addr;
        wr_data = r_clearing ? 8'd0 : i_wr_data;
    end

    // Clearing sweep, one entry per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + cer_pkg::t_cidx'(1);
            if (r_clr_addr == cer_pkg::t_cidx'(cer_pkg::COUNTER_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Simple dual-port style array: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

@@ tb/tb_coverage_event_recorder.sv @@
module tb_coverage_event_recorder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES    = 300;
    localparam int N_DIRECTED     = 20;

    // One row of the directed table: optional register settings applied
    // before the item, and the result where it is known by inspection.
    typedef struct packed {
        logic               wr_cfg;
        logic [1:0]         mode;
        logic               enable;
        logic [31:0]        max_entries;
        cer_pkg::t_in_item  item;
        logic               known;
        cer_pkg::t_out_item want;
    } t_dir_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    cer_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    cer_pkg::t_out_item o_out_data;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [3:0]         paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor state and register mirrors.
    logic [1:0]  cfg_mode;
    logic        cfg_enable;
    logic [31:0] cfg_max;
    logic [31:0] trace_head_pred;
    logic [7:0]  hit_pred [cer_pkg::COUNTER_DEPTH];

    cer_pkg::t_out_item pending_results [$];
    t_dir_row           dir_tab [N_DIRECTED];

    int mismatch_cnt   = 0;
    int unexpected_cnt = 0;
    int results_seen   = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;
    int status_hist [8];

    logic        hold_req  = 1'b0;
    logic        tx_steady = 1'b0;
    logic        rx_steady = 1'b0;
    logic [15:0] hot_idx [4];
    logic [15:0] sat_idx;

    coverage_event_recorder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Works out the result of one item and advances the trace head and hit
    // counters accordingly.
    function automatic cer_pkg::t_out_item predict_record(cer_pkg::t_in_item it);
        cer_pkg::t_out_item r;
        logic [31:0]        idx;
        r = '0;
        if (it.op == cer_pkg::OP_READ) begin
            r.entry_index = 32'(it.read_index);
            if (32'(it.read_index) >= cer_pkg::COUNTER_DEPTH) begin
                r.status = cer_pkg::ST_RANGE;
            end else begin
                r.status    = cer_pkg::ST_READ;
                r.hit_count = hit_pred[it.read_index];
            end
        end else if (!it.thread_attached || !cfg_enable
                     || cfg_mode == cer_pkg::MODE_NONE) begin
            r.status = cer_pkg::ST_IGNORED;
        end else if (cfg_mode != cer_pkg::MODE_COUNT) begin
            if (trace_head_pred >= cfg_max) begin
                r.status = cer_pkg::ST_FULL;
            end else begin
                r.status      = cer_pkg::ST_WRITTEN;
                r.entry_index = trace_head_pred;
                r.entry_pc    = it.return_addr - 64'd1;
                r.entry_stack = (cfg_mode == cer_pkg::MODE_PC_STACK) ? it.stack_size
                                                                      : 32'd0;
                trace_head_pred = trace_head_pred + 32'd1;
            end
        end else begin
            // The seen bit and the rest of the top nibble play no part.
            idx = it.guard_word & cer_pkg::IDX_MASK;
            r.entry_index = idx;
            if (idx >= cer_pkg::COUNTER_DEPTH) begin
                r.status = cer_pkg::ST_RANGE;
            end else if (hit_pred[cer_pkg::t_cidx'(idx)] < cer_pkg::HIT_LIMIT) begin
                hit_pred[cer_pkg::t_cidx'(idx)] = hit_pred[cer_pkg::t_cidx'(idx)] + 8'd1;
                r.status    = cer_pkg::ST_COUNTED;
                r.hit_count = hit_pred[cer_pkg::t_cidx'(idx)];
            end else begin
                r.status    = cer_pkg::ST_SATURATED;
                r.hit_count = hit_pred[cer_pkg::t_cidx'(idx)];
            end
        end
        r.trace_count = trace_head_pred;
        return r;
    endfunction

    // Random item; guards lean towards in-range and frequently hit indexes.
    function automatic cer_pkg::t_in_item rand_item(int read_pct, int detach_pct);
        cer_pkg::t_in_item it;
        int                g;
        it.op              = ($urandom_range(0, 99) < read_pct) ? cer_pkg::OP_READ
                                                                 : cer_pkg::OP_EVENT;
        it.thread_attached = ($urandom_range(0, 99) >= detach_pct);
        it.return_addr     = {$urandom, $urandom};
        it.stack_size      = $urandom;
        it.read_index      = ($urandom_range(0, 1) == 0) ? hot_idx[$urandom_range(0, 3)]
                                                          : 16'($urandom);
        g = $urandom_range(0, 9);
        if (g < 2) begin
            it.guard_word = $urandom;
        end else if (g < 6) begin
            it.guard_word = {4'($urandom), 12'd0, hot_idx[$urandom_range(0, 3)]};
        end else begin
            it.guard_word = {4'($urandom), 12'd0, 16'($urandom)};
        end
        return it;
    endfunction

    // Offers one input transaction and returns at the edge that accepts it.
    // Valid is only lowered when a gap follows, never between back-to-back
    // transactions.
    task automatic send_item(cer_pkg::t_in_item it, logic use_fixed,
                             cer_pkg::t_out_item fixed);
        cer_pkg::t_out_item want;
        int                 gap;
        want = predict_record(it);
        if (use_fixed) begin
            want = fixed;
        end
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pending_results.push_back(want);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Stops offering and waits until every expected result has come back,
    // then lets the pipeline settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle until pready, then a
    // return to idle so that back-to-back writes keep their setup phase.
    task automatic cfg_write(logic [1:0] which, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (which)
            cer_pkg::REG_MODE:   cfg_mode   = val[1:0];
            cer_pkg::REG_ENABLE: cfg_enable = val[0];
            cer_pkg::REG_MAX:    cfg_max    = val;
            default:             ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [1:0] mode, logic en, logic [31:0] max_e);
        drain();
        cfg_write(cer_pkg::REG_MODE, {30'd0, mode});
        cfg_write(cer_pkg::REG_ENABLE, {31'd0, en});
        cfg_write(cer_pkg::REG_MAX, max_e);
    endtask

    task automatic random_items(int n, int read_pct, int detach_pct);
        for (int k = 0; k < n; k++) begin
            send_item(rand_item(read_pct, detach_pct), 1'b0, '0);
        end
    endtask

    // Output side: random stalls, steady stretches, and one long hold-off
    // on request so that the pipeline fills and input ready drops.
    initial begin : rx_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !rx_steady && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() + 1;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Result checking against the oldest expectation, and the idle counter
    // that feeds the watchdog.
    always @(posedge i_clk) begin
        cer_pkg::t_out_item want;
        logic               bad;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                status_hist[o_out_data.status]++;
                if (pending_results.size() == 0) begin
                    unexpected_cnt++;
                    $display("Unexpected result transaction: status %0d index %0h",
                             o_out_data.status, o_out_data.entry_index);
                end else begin
                    want = pending_results.pop_front();
                    bad  = (o_out_data.status      !== want.status)      ||
                           (o_out_data.entry_index !== want.entry_index) ||
                           (o_out_data.entry_pc    !== want.entry_pc)    ||
                           (o_out_data.entry_stack !== want.entry_stack) ||
                           (o_out_data.hit_count   !== want.hit_count)   ||
                           (o_out_data.trace_count !== want.trace_count);
                    if (bad) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("Mismatch on result %0d:", results_seen);
                            $display("  expected st=%0d idx=%0h pc=%0h stk=%0h hits=%0d head=%0h",
                                     want.status, want.entry_index, want.entry_pc,
                                     want.entry_stack, want.hit_count, want.trace_count);
                            $display("  actual   st=%0d idx=%0h pc=%0h stk=%0h hits=%0d head=%0h",
                                     o_out_data.status, o_out_data.entry_index,
                                     o_out_data.entry_pc, o_out_data.entry_stack,
                                     o_out_data.hit_count, o_out_data.trace_count);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: the reset clearing sweep fits well inside the limit.
    initial begin : watchdog
        do @(posedge i_clk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_coverage_event_recorder NOT OK");
        $finish;
    end

    initial begin : main_seq
        cfg_mode        = cer_pkg::MODE_NONE;
        cfg_enable      = 1'b0;
        cfg_max         = cer_pkg::MAX_ENTRIES_RST;
        trace_head_pred = '0;
        foreach (hit_pred[k]) hit_pred[k] = '0;
        foreach (status_hist[k]) status_hist[k] = 0;
        hot_idx[0] = 16'($urandom);
        hot_idx[1] = 16'($urandom);
        hot_idx[2] = 16'h0000;
        hot_idx[3] = 16'hffff;
        sat_idx    = 16'($urandom);

        // Directed rows: reset state, pc wrap, stack carry, full trace,
        // lowered capacity, guard seen bit, counter range, reads.
        dir_tab = '{
            '{1'b0, cer_pkg::MODE_NONE, 1'b0, 32'd0,
              '{cer_pkg::OP_READ, 1'b0, 64'd0, 32'd0, 32'd0, 16'h0000},
              1'b1, '{cer_pkg::ST_READ, 32'd0, 64'd0, 32'd0, 8'd0, 32'd0}},
            '{1'b0, cer_pkg::MODE_NONE, 1'b0, 32'd0,
              '{cer_pkg::OP_READ, 1'b1, 64'd0, 32'd0, 32'd0, 16'hffff},
              1'b1, '{cer_pkg::ST_READ, 32'h0000ffff, 64'd0, 32'd0, 8'd0, 32'd0}},
            '{1'b0, cer_pkg::MODE_NONE, 1'b0, 32'd0,
              '{cer_pkg::OP_EVENT, 1'b1, 64'd5, 32'd1, 32'd7, 16'h0001},
              1'b1, '{cer_pkg::ST_IGNORED, 32'd0, 64'd0, 32'd0, 8'd0, 32'd0}},
            '{1'b1, cer_pkg::MODE_PC, 1'b1, 32'h0001_0000,
              '{cer_pkg::OP_EVENT, 1'b0, 64'd9, 32'd1, 32'd7, 16'h0001},
              1'b1, '{cer_pkg::ST_IGNORED, 32'd0, 64'd0, 32'd0, 8'd0, 32'd0}},
            '{1'b0, cer_pkg::MODE_PC, 1'b1, 32'd0,
              '{cer_pkg::OP_EVENT, 1'b1, 64'd0, 32'd0, 32'hffff_ffff, 16'h0000},
              1'b1, '{cer_pkg::ST_WRITTEN, 32'd0, {64{1'b1}}, 32'd0, 8'd0, 32'd1}},
            '{1'b0, cer_pkg::MODE_PC, 1'b1, 32'd0,
              '{cer_pkg::OP_EVENT, 1'b1, {64{1'b1}}, 32'hffff_ffff, 32'd3, 16'hffff},
              1'b1, '{cer_pkg::ST_WRITTEN, 32'd1, 64'hffff_ffff_ffff_fffe,
                      32'd0, 8'd0, 32'd2}},
            '{1'b1, cer_pkg::MODE_PC_STACK, 1'b1, 32'h0001_0000,
              '{cer_pkg::OP_EVENT, 1'b1, 64'd1, 32'd0, 32'hffff_ffff, 16'h0000},
              1'b1, '{cer_pkg::ST_WRITTEN, 32'd2, 64'd0, 32'hffff_ffff, 8'd0, 32'd3}},
            '{1'b0, cer_pkg::MODE_PC_STACK, 1'b1, 32'd0,
              '{cer_pkg::OP_EVENT, 1'b1, 64'h0123_4567_89ab_cdef, 32'd0, 32'd0, 16'h0000},
              1'b0, '0},
            '{1'b1, cer_pkg::MODE_PC_STACK, 1'b1, 32'd0,
              '{cer_pkg::OP_EVENT, 1'b1, 64'h0123_4567_89ab_cdef, 32'd0, 32'h1234,
                16'h0000},
              1'b1, '{cer_pkg::ST_FULL, 32'd0, 64'd0, 32'd0, 8'd0, 32'd4}},
            '{1'b1, cer_pkg::MODE_PC, 1'b0, 32'h0001_0000,
              '{cer_pkg::OP_EVENT, 1'b1, 64'h10, 32'd0, 32'd0, 16'h0000},
              1'b1, '{cer_pkg::ST_IGNORED, 32'd0, 64'd0, 32'd0, 8'd0, 32'd4}},
            '{1'b1, cer_pkg::MODE_COUNT, 1'b1, 32'hffff_ffff,
              '{cer_pkg::OP_EVENT, 1'b1, 64'h20, 32'h0000_0000, 32'd0, 16'h0000},
              1'b1, '{cer_pkg::ST_COUNTED, 32'd0, 64'd0, 32'd0, 8'd1, 32'd4}},
            '{1'b0, cer_pkg::MODE_COUNT, 1'b1, 32'd0,
              '{cer_pkg::OP_EVENT, 1'b1, 64'h30, 32'h8000_0000, 32'd0, 16'h0000},
              1'b1, '{cer_pkg::ST_COUNTED, 32'd0, 64'd0, 32'd0, 8'd2, 32'd4}},
            '{1'b0, cer_pkg::MODE_COUNT, 1'b1, 32'd0,
              '{cer_pkg::OP_EVENT, 1'b1, 64'h40, 32'hf000_ffff, 32'd0, 16'h0000},
              1'b1, '{cer_pkg::ST_COUNTED, 32'h0000_ffff, 64'd0, 32'd0, 8'd1, 32'd4}},
            '{1'b0, cer_pkg::MODE_COUNT, 1'b1, 32'd0,
              '{cer_pkg::OP_EVENT, 1'b1, 64'h50, 32'h0fff_ffff, 32'd0, 16'h0000},
              1'b1, '{cer_pkg::ST_RANGE, 32'h0fff_ffff, 64'd0, 32'd0, 8'd0, 32'd4}},
            '{1'b0, cer_pkg::MODE_COUNT, 1'b1, 32'd0,
              '{cer_pkg::OP_EVENT, 1'b1, 64'h60, 32'h0001_0000, 32'd0, 16'h0000},
              1'b1, '{cer_pkg::ST_RANGE, 32'h0001_0000, 64'd0, 32'd0, 8'd0, 32'd4}},
            '{1'b0, cer_pkg::MODE_COUNT, 1'b1, 32'd0,
              '{cer_pkg::OP_EVENT, 1'b1, 64'h70, 32'h7fff_0003, 32'd0, 16'h0000},
              1'b0, '0},
            '{1'b0, cer_pkg::MODE_COUNT, 1'b1, 32'd0,
              '{cer_pkg::OP_READ, 1'b1, 64'd0, 32'd0, 32'd0, 16'h0000},
              1'b1, '{cer_pkg::ST_READ, 32'd0, 64'd0, 32'd0, 8'd2, 32'd4}},
            '{1'b0, cer_pkg::MODE_COUNT, 1'b1, 32'd0,
              '{cer_pkg::OP_READ, 1'b0, 64'd0, 32'h0000_0005, 32'd0, 16'hffff},
              1'b0, '0},
            '{1'b1, cer_pkg::MODE_NONE, 1'b1, 32'h0001_0000,
              '{cer_pkg::OP_EVENT, 1'b1, 64'h80, 32'd0, 32'd0, 16'h0000},
              1'b1, '{cer_pkg::ST_IGNORED, 32'd0, 64'd0, 32'd0, 8'd0, 32'd4}},
            '{1'b0, cer_pkg::MODE_NONE, 1'b1, 32'd0,
              '{cer_pkg::OP_READ, 1'b0, 64'h90, 32'd0, 32'd0, 16'h0000},
              1'b0, '0}
        };

        // Reset is held first and then released; the block then sweeps its hit store.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            if (dir_tab[r].wr_cfg) begin
                set_config(dir_tab[r].mode, dir_tab[r].enable, dir_tab[r].max_entries);
            end
            send_item(dir_tab[r].item, dir_tab[r].known, dir_tab[r].want);
        end

        // Pc trace filling up to a small capacity, with a full drain halfway.
        set_config(cer_pkg::MODE_PC, 1'b1, 32'd40);
        random_items(30, 10, 15);
        drain();
        random_items(30, 10, 15);

        // Pc and stack trace with the largest capacity.
        set_config(cer_pkg::MODE_PC_STACK, 1'b1, 32'hffff_ffff);
        random_items(60, 10, 15);

        // Capacity lowered below the current head.
        set_config(cer_pkg::MODE_PC, 1'b1, 32'd5);
        random_items(20, 10, 10);

        // Hit counters with one long receiver hold-off.
        set_config(cer_pkg::MODE_COUNT, 1'b1, 32'h0001_0000);
        random_items(30, 15, 10);
        hold_req = 1'b1;
        random_items(40, 15, 10);

        // Drive one counter into saturation; first part back to back so
        // that consecutive updates of one entry follow each other closely.
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int k = 0; hit_pred[sat_idx] < cer_pkg::HIT_LIMIT || k < 10; k++) begin
            cer_pkg::t_in_item it;
            if (k == 120) begin
                tx_steady = 1'b0;
                rx_steady = 1'b0;
            end
            it = rand_item(8, 3);
            it.read_index = sat_idx;
            if ($urandom_range(0, 4) != 0) begin
                it.guard_word = {4'($urandom), 12'd0, sat_idx};
            end
            send_item(it, 1'b0, '0);
        end

        // Nothing is recorded: mode none, then recording disabled.
        set_config(cer_pkg::MODE_NONE, 1'b1, 32'd0);
        random_items(15, 15, 20);
        set_config(cer_pkg::MODE_PC_STACK, 1'b0, 32'hffff_ffff);
        random_items(15, 15, 20);

        drain();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d input transactions (%0d directed), checked %0d results.",
                 items_sent, N_DIRECTED, results_seen);
        $display("Status mix ign/wr/full/cnt/sat/range/read: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 status_hist[0], status_hist[1], status_hist[2], status_hist[3],
                 status_hist[4], status_hist[5], status_hist[6]);
        if (mismatch_cnt == 0 && unexpected_cnt == 0 && pending_results.size() == 0) begin
            $display("tb_coverage_event_recorder OK");
        end else begin
            $display("Mismatches %0d, unexpected %0d, missing %0d",
                     mismatch_cnt, unexpected_cnt, pending_results.size());
            $display("tb_coverage_event_recorder NOT OK");
        end
        $finish;
    end

endmodule
